>>> rtl/core/lifrna_pkg.sv
// Shared types, constants and fixed-point helpers for the recurrent LIF neuron array.
// Used by lifrna_cell, lif_recurrent_neuron_array and lifrna_chk; depends on nothing.
package lifrna_pkg;

  localparam int NEURONS   = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(NEURONS);
  // bias + product + one weight per neuron, plus headroom
  localparam int ACC_W     = 32 + $clog2(NEURONS + 2) + 1;
  localparam int MUL_W     = 65;
  localparam int CNT_W     = 14;
  localparam int PC_W      = $clog2(NEURONS + 1);

  localparam logic [16:0]       DECAY_ONE   = 17'h10000;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 14'h3FFF;
  localparam logic [16:0]       DECAY_RST   = 17'd61565;
  localparam logic signed [31:0] THRESH_RST = 32'sd65536;
  localparam logic signed [31:0] RSTPOT_RST = 32'sd0;
  localparam logic signed [31:0] REST_RST   = 32'sd0;

  typedef enum logic [2:0] {
    REQ_IN_W  = 3'd0,
    REQ_REC_W = 3'd1,
    REQ_BIAS  = 3'd2,
    REQ_CUR   = 3'd3,
    REQ_RUN   = 3'd4,
    REQ_RESET = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    CFG_DECAY     = 2'd0,
    CFG_THRESH    = 2'd1,
    CFG_RESET_POT = 2'd2,
    CFG_REST_POT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_PROD,
    ST_LEAKA,
    ST_LEAKB,
    ST_FIRE,
    ST_RESP
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WR_INW,
    OP_WR_REC,
    OP_WR_BIAS,
    OP_WR_CUR,
    OP_RESET,
    OP_ACC,
    OP_PROD,
    OP_LEAKA,
    OP_LEAKB,
    OP_FIRE
  } cell_op_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         target_neuron;
    logic [3:0]         source_neuron;
    logic signed [31:0] value;
    logic [4:0]         active_inputs;
    logic [9:0]         repeat_steps;
  } in_t;

  typedef struct packed {
    logic [15:0]        spike_mask;
    logic [13:0]        spike_total;
    logic signed [31:0] potential_out;
  } out_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_op_e           op;
    logic               first;
    logic signed [31:0] value;
    logic [IDX_W-1:0]   wr_src;
    logic               wr_src_ok;
    logic [16:0]        decay;
    logic signed [31:0] thresh;
    logic signed [31:0] reset_pot;
    logic signed [31:0] rest_pot;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat_mul(input logic signed [MUL_W-1:0] x);
    if (x[MUL_W-1:31] == '0 || x[MUL_W-1:31] == '1) return x[31:0];
    return x[MUL_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] x);
    if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1) return x[31:0];
    return x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Q16.16 product: round half up, then saturate
  function automatic logic signed [31:0] round_prod(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] t;
    t = p + (MUL_W'(1) << (FRAC_BITS - 1));
    return sat_mul(t >>> FRAC_BITS);
  endfunction

endpackage

>>> rtl/core/lifrna_cell.sv
// One neuron of the array: its stores, its potential, a shared multiplier
// and one bit of the spike ring. Depends on lifrna_pkg.
module lifrna_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lifrna_pkg::cell_ctl_t       ctl_i,
  input  logic                        sel_i,
  input  logic                        active_i,
  input  logic [lifrna_pkg::IDX_W-1:0] ridx_i,
  input  logic                        spike_i,
  output logic                        spike_o,
  output logic                        fire_o,
  output logic signed [31:0]          v_o
);

  localparam int N  = lifrna_pkg::NEURONS;
  localparam int AW = lifrna_pkg::ACC_W;
  localparam int MW = lifrna_pkg::MUL_W;

  logic signed [31:0] inw_q, bias_q, cur_q, v_q, v_d;
  logic               spike_q, spike_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [MW-1:0] mul_q, sum_q, mul_w, leak_sum;
  logic signed [31:0] mul_a, isyn, w_term, p_term, vn;
  logic signed [32:0] mul_b;
  logic [16:0]        one_minus;
  logic               fire;

  // recurrent weight row: memory with registered read, valid bit per entry
  logic [31:0]        row_mem [N];
  logic [N-1:0]       row_vld_q;
  logic [31:0]        rdata_q;
  logic               rvld_q, bit_q, add_en_q;
  logic               rec_we;

  assign rec_we = (ctl_i.op == lifrna_pkg::OP_WR_REC) && sel_i && ctl_i.wr_src_ok;

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      row_mem[ctl_i.wr_src] <= ctl_i.value;
    end
    rdata_q <= row_mem[ridx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
      bit_q     <= 1'b0;
      add_en_q  <= 1'b0;
    end else begin
      if (rec_we) row_vld_q[ctl_i.wr_src] <= 1'b1;
      rvld_q   <= row_vld_q[ridx_i];
      bit_q    <= spike_q;
      add_en_q <= (ctl_i.op == lifrna_pkg::OP_ACC);
    end
  end

  // multiplier operand select
  assign one_minus = lifrna_pkg::DECAY_ONE - ctl_i.decay;
  assign isyn      = lifrna_pkg::sat_acc(acc_q);

  always_comb begin
    case (ctl_i.op)
      lifrna_pkg::OP_LEAKA: begin
        mul_a = isyn;
        mul_b = {16'b0, one_minus};
      end
      lifrna_pkg::OP_LEAKB: begin
        mul_a = v_q;
        mul_b = {16'b0, ctl_i.decay};
      end
      default: begin
        mul_a = cur_q;
        mul_b = {inw_q[31], inw_q};
      end
    endcase
  end

  assign mul_w = MW'(mul_a) * MW'(mul_b);

  // synaptic sum
  assign w_term = (add_en_q && bit_q && rvld_q) ? $signed(rdata_q) : 32'sd0;
  assign p_term = (ctl_i.op == lifrna_pkg::OP_PROD && active_i) ?
                  lifrna_pkg::round_prod(mul_q) : 32'sd0;

  always_comb begin
    if (ctl_i.op == lifrna_pkg::OP_ACC && ctl_i.first) begin
      acc_d = AW'(bias_q);
    end else begin
      acc_d = acc_q + AW'(w_term) + AW'(p_term);
    end
  end

  // leak and fire
  assign leak_sum = sum_q + mul_q;
  assign vn       = lifrna_pkg::sat_mul(leak_sum >>> 16);
  assign fire     = (vn >= ctl_i.thresh);

  always_comb begin
    v_d     = v_q;
    spike_d = spike_q;
    case (ctl_i.op)
      lifrna_pkg::OP_ACC: spike_d = spike_i;
      lifrna_pkg::OP_FIRE: begin
        spike_d = fire;
        v_d     = fire ? ctl_i.reset_pot : vn;
      end
      lifrna_pkg::OP_RESET: begin
        spike_d = 1'b0;
        v_d     = ctl_i.rest_pot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inw_q   <= '0;
      bias_q  <= '0;
      cur_q   <= '0;
      v_q     <= lifrna_pkg::REST_RST;
      spike_q <= 1'b0;
    end else begin
      v_q     <= v_d;
      spike_q <= spike_d;
      if (sel_i && ctl_i.op == lifrna_pkg::OP_WR_INW)  inw_q  <= ctl_i.value;
      if (sel_i && ctl_i.op == lifrna_pkg::OP_WR_BIAS) bias_q <= ctl_i.value;
      if (sel_i && ctl_i.op == lifrna_pkg::OP_WR_CUR)  cur_q  <= ctl_i.value;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    case (ctl_i.op)
      lifrna_pkg::OP_ACC:   if (ctl_i.first) mul_q <= mul_w;
      lifrna_pkg::OP_LEAKA: mul_q <= mul_w;
      lifrna_pkg::OP_LEAKB: begin
        sum_q <= mul_q + MW'(32768);
        mul_q <= mul_w;
      end
      default: ;
    endcase
  end

  assign spike_o = spike_q;
  assign fire_o  = (ctl_i.op == lifrna_pkg::OP_FIRE) && fire;
  assign v_o     = v_q;

endmodule

>>> rtl/core/lif_recurrent_neuron_array.sv
// Top level of the recurrent LIF neuron array: sequencer, configuration
// registers, result register and the ring of cells. Depends on lifrna_pkg, lifrna_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one request:
//   a weight, bias or current write, a potential reset, or a run of
//   repeat_steps timesteps. Every request gives exactly one result on the
//   output channel (out_valid_o/out_ready_i/out_data_o).
//   Configuration writes (cfg_valid_i/cfg_index_i/cfg_data_i) are always
//   taken; issue them only while the block is idle.
// Timing:
//   A write or reset request passes through ST_RESP and raises out_valid_o
//   once the output register is free. In a run, each timestep the spike
//   ring rotates through all NEURONS cells, one recurrent weight read per
//   cell per cycle, then ST_PROD, ST_LEAKA, ST_LEAKB and ST_FIRE do product,
//   leak and fire on the per-cell multiplier. One request is in work at a time.
// Reset: all stores, spike bits and potentials clear, registers take their
//   default values; the block is ready at once.
// Stall: the result waits in the output register; a new request is still
//   taken and its result waits until the output register frees up.
module lif_recurrent_neuron_array (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lifrna_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lifrna_pkg::out_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int N  = lifrna_pkg::NEURONS;
  localparam int IW = lifrna_pkg::IDX_W;
  localparam int SW = (IW > 4) ? IW : 4;

  lifrna_pkg::state_e state_q, state_d;
  logic [IW-1:0]      j_q;
  logic [9:0]         steps_q;
  logic [13:0]        count_q;
  logic [3:0]         tgt_q;
  logic [4:0]         active_q;

  logic [16:0]        decay_q, decay_eff;
  logic signed [31:0] thresh_q, rstpot_q, rest_q;

  logic               out_valid_q, out_load;
  lifrna_pkg::out_t   out_q, out_d;

  lifrna_pkg::cell_ctl_t ctl;
  logic               in_xfer;
  logic [N-1:0]       sel, active, spike_w, fire_w;
  logic [IW-1:0]      ridx [N];
  logic signed [31:0] v_w [N];
  logic [SW-1:0]      tgt_in_ext, src_in_ext, tgt_q_ext;
  logic               tgt_ok_q;
  logic [14:0]        count_sum;
  logic [15:0]        mask;

  function automatic logic [lifrna_pkg::PC_W-1:0] popcnt(input logic [N-1:0] b);
    logic [lifrna_pkg::PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < N; i++) c = c + lifrna_pkg::PC_W'(b[i]);
    return c;
  endfunction

  assign in_ready_o  = (state_q == lifrna_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign decay_eff   = (decay_q > lifrna_pkg::DECAY_ONE) ? lifrna_pkg::DECAY_ONE : decay_q;

  assign tgt_in_ext = SW'(in_data_i.target_neuron);
  assign src_in_ext = SW'(in_data_i.source_neuron);
  assign tgt_q_ext  = SW'(tgt_q);
  assign tgt_ok_q   = (32'(tgt_q) < N);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q  <= lifrna_pkg::DECAY_RST;
      thresh_q <= lifrna_pkg::THRESH_RST;
      rstpot_q <= lifrna_pkg::RSTPOT_RST;
      rest_q   <= lifrna_pkg::REST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lifrna_pkg::CFG_DECAY:     decay_q  <= cfg_data_i[16:0];
        lifrna_pkg::CFG_THRESH:    thresh_q <= cfg_data_i;
        lifrna_pkg::CFG_RESET_POT: rstpot_q <= cfg_data_i;
        lifrna_pkg::CFG_REST_POT:  rest_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lifrna_pkg::ST_IDLE:
        if (in_xfer) begin
          if (in_data_i.req_type == lifrna_pkg::REQ_RUN && in_data_i.repeat_steps != '0)
            state_d = lifrna_pkg::ST_ACC;
          else
            state_d = lifrna_pkg::ST_RESP;
        end
      lifrna_pkg::ST_ACC:
        if (j_q == IW'(N - 1)) state_d = lifrna_pkg::ST_PROD;
      lifrna_pkg::ST_PROD:  state_d = lifrna_pkg::ST_LEAKA;
      lifrna_pkg::ST_LEAKA: state_d = lifrna_pkg::ST_LEAKB;
      lifrna_pkg::ST_LEAKB: state_d = lifrna_pkg::ST_FIRE;
      lifrna_pkg::ST_FIRE:
        state_d = (steps_q == 10'd1) ? lifrna_pkg::ST_RESP : lifrna_pkg::ST_ACC;
      lifrna_pkg::ST_RESP:
        if (out_load) state_d = lifrna_pkg::ST_IDLE;
      default: state_d = lifrna_pkg::ST_IDLE;
    endcase
  end

  // cell control outputs
  always_comb begin
    ctl.op        = lifrna_pkg::OP_NONE;
    ctl.first     = (j_q == '0);
    ctl.value     = in_data_i.value;
    ctl.wr_src    = src_in_ext[IW-1:0];
    ctl.wr_src_ok = (32'(in_data_i.source_neuron) < N);
    ctl.decay     = decay_eff;
    ctl.thresh    = thresh_q;
    ctl.reset_pot = rstpot_q;
    ctl.rest_pot  = rest_q;
    case (state_q)
      lifrna_pkg::ST_IDLE:
        if (in_xfer) begin
          case (in_data_i.req_type)
            lifrna_pkg::REQ_IN_W:  ctl.op = lifrna_pkg::OP_WR_INW;
            lifrna_pkg::REQ_REC_W: ctl.op = lifrna_pkg::OP_WR_REC;
            lifrna_pkg::REQ_BIAS:  ctl.op = lifrna_pkg::OP_WR_BIAS;
            lifrna_pkg::REQ_CUR:   ctl.op = lifrna_pkg::OP_WR_CUR;
            lifrna_pkg::REQ_RESET: ctl.op = lifrna_pkg::OP_RESET;
            default:               ctl.op = lifrna_pkg::OP_NONE;
          endcase
        end
      lifrna_pkg::ST_ACC:   ctl.op = lifrna_pkg::OP_ACC;
      lifrna_pkg::ST_PROD:  ctl.op = lifrna_pkg::OP_PROD;
      lifrna_pkg::ST_LEAKA: ctl.op = lifrna_pkg::OP_LEAKA;
      lifrna_pkg::ST_LEAKB: ctl.op = lifrna_pkg::OP_LEAKB;
      lifrna_pkg::ST_FIRE:  ctl.op = lifrna_pkg::OP_FIRE;
      default: ;
    endcase
  end

  // saturating spike count
  assign count_sum = 15'(count_q) + 15'(popcnt(fire_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lifrna_pkg::ST_IDLE;
      j_q      <= '0;
      steps_q  <= '0;
      count_q  <= '0;
      tgt_q    <= '0;
      active_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        j_q      <= '0;
        steps_q  <= in_data_i.repeat_steps;
        count_q  <= '0;
        tgt_q    <= in_data_i.target_neuron;
        active_q <= in_data_i.active_inputs;
      end
      if (state_q == lifrna_pkg::ST_ACC) begin
        j_q <= (j_q == IW'(N - 1)) ? '0 : j_q + 1'b1;
      end
      if (state_q == lifrna_pkg::ST_FIRE) begin
        steps_q <= steps_q - 1'b1;
        count_q <= (count_sum > 15'(lifrna_pkg::COUNT_MAX)) ?
                   lifrna_pkg::COUNT_MAX : count_sum[13:0];
      end
    end
  end

  // ring of cells; cell k reads the weight of the neuron whose bit it holds
  for (genvar k = 0; k < N; k++) begin : g_cell
    assign sel[k]    = (32'(tgt_in_ext) == k);
    assign active[k] = (32'(active_q) > k);
    assign ridx[k]   = (IW'(k) >= j_q) ? IW'(k) - j_q : IW'(k + N) - j_q;

    lifrna_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .sel_i    (sel[k]),
      .active_i (active[k]),
      .ridx_i   (ridx[k]),
      .spike_i  (spike_w[(k + N - 1) % N]),
      .spike_o  (spike_w[k]),
      .fire_o   (fire_w[k]),
      .v_o      (v_w[k])
    );
  end

  for (genvar n = 0; n < 16; n++) begin : g_mask
    if (n < N) begin : g_on
      assign mask[n] = spike_w[n];
    end else begin : g_off
      assign mask[n] = 1'b0;
    end
  end

  // result register
  assign out_load = (state_q == lifrna_pkg::ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_d.spike_mask    = mask;
    out_d.spike_total   = count_q;
    out_d.potential_out = tgt_ok_q ? v_w[tgt_q_ext[IW-1:0]] : 32'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/lifrna_chk.sv
// Port-level checker for lif_recurrent_neuron_array, attached by bind.
// Depends on lifrna_pkg.
module lifrna_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input lifrna_pkg::in_t   in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lifrna_pkg::out_t  out_data_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // one request in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // a new result follows a busy cycle
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a request in work");

  // a request other than a run is answered straight from ST_RESP when the output is free
  a_write_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    in_data_i.req_type != lifrna_pkg::REQ_RUN |-> ##2 out_valid_o)
    else $error("write result late");

endmodule

bind lif_recurrent_neuron_array lifrna_chk u_lifrna_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> sim/testbench.sv
// Self-checking testbench for lif_recurrent_neuron_array: a scoreboard class
// predicts every result from the accepted requests and checks the output stream.
// Depends on lifrna_pkg and the lif_recurrent_neuron_array RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int         WATCHDOG_LIMIT = 100000;

  // Scoreboard: own copy of neuron state and registers, plus the queue of
  // results still owed by the block.
  class lif_scoreboard;
    longint in_w[16];
    longint rec_w[16][16];
    longint bias[16];
    longint cur[16];
    longint vmem[16];
    bit [15:0] spikes;
    longint decay, thresh, reset_pot, rest_pot;
    lifrna_pkg::out_t owed_q[$];
    int errors;

    function new();
      for (int n = 0; n < 16; n++) begin
        in_w[n] = 0; bias[n] = 0; cur[n] = 0; vmem[n] = 0;
        for (int m = 0; m < 16; m++) rec_w[n][m] = 0;
      end
      spikes = '0;
      decay = 61565; thresh = 65536; reset_pot = 0; rest_pot = 0;
      errors = 0;
    endfunction

    static function longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Q16.16 product, round half up
    static function longint mul_q(longint a, longint b);
      longint p;
      p = a * b;
      return sat32((p + 64'sd32768) >>> 16);
    endfunction

    function longint leak(longint v, longint isyn);
      longint d, s;
      d = (decay > 65536) ? 65536 : decay;
      s = v * d + isyn * (65536 - d) + 64'sd32768;
      return sat32(s >>> 16);
    endfunction

    function void write_reg(lifrna_pkg::cfg_reg_e idx, logic [31:0] d);
      case (idx)
        lifrna_pkg::CFG_DECAY:     decay = longint'(d[16:0]);
        lifrna_pkg::CFG_THRESH:    thresh = longint'($signed(d));
        lifrna_pkg::CFG_RESET_POT: reset_pot = longint'($signed(d));
        lifrna_pkg::CFG_REST_POT:  rest_pot = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function void note_request(lifrna_pkg::in_t r);
      longint val, acc;
      int tgt, src;
      bit [15:0] nxt;
      int count;
      lifrna_pkg::out_t res;
      val = longint'($signed(r.value));
      tgt = r.target_neuron;
      src = r.source_neuron;
      count = 0;
      case (r.req_type)
        lifrna_pkg::REQ_IN_W:  in_w[tgt] = val;
        lifrna_pkg::REQ_REC_W: rec_w[tgt][src] = val;
        lifrna_pkg::REQ_BIAS:  bias[tgt] = val;
        lifrna_pkg::REQ_CUR:   cur[tgt] = val;
        lifrna_pkg::REQ_RUN: begin
          for (int t = 0; t < r.repeat_steps; t++) begin
            for (int n = 0; n < 16; n++) begin
              acc = bias[n];
              if (n < r.active_inputs) acc += mul_q(cur[n], in_w[n]);
              for (int m = 0; m < 16; m++)
                if (spikes[m]) acc += rec_w[n][m];
              vmem[n] = leak(vmem[n], sat32(acc));
              nxt[n] = 1'b0;
              if (vmem[n] >= thresh) begin
                nxt[n] = 1'b1;
                vmem[n] = reset_pot;
                if (count < 16383) count++;
              end
            end
            spikes = nxt;
          end
        end
        lifrna_pkg::REQ_RESET: begin
          for (int n = 0; n < 16; n++) vmem[n] = rest_pot;
          spikes = '0;
        end
        default: ;
      endcase
      res.spike_mask = spikes;
      res.spike_total = count[13:0];
      res.potential_out = vmem[tgt][31:0];
      owed_q.push_back(res);
    endfunction

    function void check_result(lifrna_pkg::out_t got);
      lifrna_pkg::out_t exp_r;
      if (owed_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.spike_mask !== exp_r.spike_mask) begin
        $error("spike_mask: expected %h, got %h", exp_r.spike_mask, got.spike_mask);
        errors++;
      end
      if (got.spike_total !== exp_r.spike_total) begin
        $error("spike_total: expected %0d, got %0d", exp_r.spike_total, got.spike_total);
        errors++;
      end
      if (got.potential_out !== exp_r.potential_out) begin
        $error("potential_out: expected %0d, got %0d",
               exp_r.potential_out, got.potential_out);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  lifrna_pkg::in_t  in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  lifrna_pkg::out_t out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [31:0]      cfg_data_i = '0;

  lif_recurrent_neuron_array uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  lif_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(lifrna_pkg::in_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(lifrna_pkg::cfg_reg_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] dc, logic [31:0] th, logic [31:0] rp,
                          logic [31:0] rs);
    drain();
    write_reg(lifrna_pkg::CFG_DECAY, dc);
    write_reg(lifrna_pkg::CFG_THRESH, th);
    write_reg(lifrna_pkg::CFG_RESET_POT, rp);
    write_reg(lifrna_pkg::CFG_REST_POT, rs);
  endtask

  function automatic lifrna_pkg::in_t make_req(logic [2:0] kind, int tgt, int src,
                                               logic [31:0] v, int act, int steps);
    lifrna_pkg::in_t r;
    r.req_type = kind;
    r.target_neuron = tgt[3:0];
    r.source_neuron = src[3:0];
    r.value = v;
    r.active_inputs = act[4:0];
    r.repeat_steps = steps[9:0];
    return r;
  endfunction

  // mostly modest Q16.16 values so spiking stays interesting
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    if ($urandom_range(0, 4) == 0) return $urandom;
    v = $urandom_range(0, 32'h3FFFF);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic lifrna_pkg::in_t random_req();
    int sel, steps;
    logic [2:0] kind;
    sel = $urandom_range(0, 99);
    if (sel < 15)      kind = lifrna_pkg::REQ_IN_W;
    else if (sel < 35) kind = lifrna_pkg::REQ_REC_W;
    else if (sel < 48) kind = lifrna_pkg::REQ_BIAS;
    else if (sel < 62) kind = lifrna_pkg::REQ_CUR;
    else if (sel < 88) kind = lifrna_pkg::REQ_RUN;
    else if (sel < 96) kind = lifrna_pkg::REQ_RESET;
    else if (sel < 98) kind = REQ_SPARE_A;
    else               kind = REQ_SPARE_B;
    steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 4);
    return make_req(kind, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
                    $urandom_range(0, 31), steps);
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: saturating products, extreme weights, run corners, spare codes
    send_request(make_req(lifrna_pkg::REQ_IN_W, 0, 0, 32'h7FFF_FFFF, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_CUR, 0, 0, 32'h7FFF_FFFF, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_IN_W, 15, 0, 32'h8000_0000, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_CUR, 15, 0, 32'h8000_0000, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_REC_W, 3, 15, 32'h8000_0000, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_REC_W, 15, 0, 32'h7FFF_FFFF, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_BIAS, 1, 0, 32'h0002_0000, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_BIAS, 2, 0, 32'h8000_0000, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_CUR, 5, 0, 32'hFFFF_FFFF, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_IN_W, 5, 0, 32'h0000_0001, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_RUN, 0, 0, 0, 0, 0));
    send_request(make_req(lifrna_pkg::REQ_RUN, 15, 0, 0, 16, 1));
    send_request(make_req(lifrna_pkg::REQ_RUN, 1, 0, 0, 31, 3));
    send_request(make_req(REQ_SPARE_A, 4, 9, 32'h1234_5678, 7, 2));
    send_request(make_req(REQ_SPARE_B, 0, 0, 0, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_RUN, 0, 0, 0, 16, 2));
    send_request(make_req(lifrna_pkg::REQ_RESET, 2, 0, 0, 0, 1));
    send_request(make_req(lifrna_pkg::REQ_RUN, 1, 0, 0, 16, 1023));
    send_request(make_req(lifrna_pkg::REQ_RUN, 15, 0, 0, 16, 2));

    // random phases, each with its own register setting and idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_regs(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        1: set_regs(32'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        2: set_regs(32'h0001_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        default: set_regs($urandom_range(20000, 65535), 32'h0000_8000, 32'd0, 32'd0);
      endcase
      send_idle_pct = (phase == 1) ? 70 : (phase == 3) ? 33 : 0;
      recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 33 : 0;
      send_request(make_req(lifrna_pkg::REQ_RESET, 0, 0, 0, 0, 1));
      // threshold at minimum: everyone fires every step, count reaches 16368, below COUNT_MAX
      if (phase == 0) send_request(make_req(lifrna_pkg::REQ_RUN, 7, 0, 0, 16, 1023));
      repeat (145) send_request(random_req());
    end

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
